// ----- rtl/kas_pkg.sv -----
package kas_pkg;

  localparam int CFG_W               = 12;
  localparam int CFG_IDX_W           = 2;
  localparam int BOARD_WIDTH_DEF     = 10;
  localparam int STEP_COUNT_BITS_DEF = 12;

  localparam logic [CFG_W-1:0] DELAY_RESET  = 12'd10;
  localparam logic [CFG_W-1:0] REPEAT_RESET = 12'd2;
  localparam logic [CFG_W-1:0] SWITCH_RESET = 12'd0;

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [2:0] {
    CMD_ROTCW    = 3'd0,
    CMD_ROTCCW   = 3'd1,
    CMD_HARDDROP = 3'd2,
    CMD_HOLD     = 3'd3,
    CMD_SOFTON   = 3'd4,
    CMD_SOFTOFF  = 3'd5,
    CMD_LEFT     = 3'd6,
    CMD_RIGHT    = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    EDGE_ROTCW    = 4'd0,
    EDGE_ROTCCW   = 4'd1,
    EDGE_HARDDROP = 4'd2,
    EDGE_HOLD     = 4'd3,
    EDGE_SOFTON   = 4'd4,
    EDGE_SOFTOFF  = 4'd5,
    EDGE_LPRESS   = 4'd6,
    EDGE_RPRESS   = 4'd7,
    EDGE_LREL     = 4'd8,
    EDGE_RREL     = 4'd9
  } edge_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY  = 2'd0,
    CFG_REPEAT = 2'd1,
    CFG_SWITCH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       mode;
    logic [3:0] edge_code;
    logic       left_held;
    logic       right_held;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] delay_steps;
    logic [CFG_W-1:0] repeat_steps;
    logic [CFG_W-1:0] switch_delay_steps;
  } cfg_t;

  // First result of an item and the command used for every later one.
  typedef struct packed {
    cmd_e cmd_a;
    cmd_e cmd_b;
  } cmd_pair_t;

  function automatic cmd_e move_cmd(input dir_e dir);
    return (dir == DIR_LEFT) ? CMD_LEFT : CMD_RIGHT;
  endfunction

endpackage

// ----- rtl/kas_cfg_regs.sv -----
module kas_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [kas_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [kas_pkg::CFG_W-1:0]      wr_data,
  output kas_pkg::cfg_t                  cfg
);

  kas_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_steps        <= kas_pkg::DELAY_RESET;
      cfg_r.repeat_steps       <= kas_pkg::REPEAT_RESET;
      cfg_r.switch_delay_steps <= kas_pkg::SWITCH_RESET;
    end else if (wr_en) begin
      case (wr_index)
        kas_pkg::CFG_DELAY:  cfg_r.delay_steps        <= wr_data;
        kas_pkg::CFG_REPEAT: cfg_r.repeat_steps       <= wr_data;
        kas_pkg::CFG_SWITCH: cfg_r.switch_delay_steps <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/kas_core.sv -----
module kas_core #(
  parameter int BOARD_WIDTH     = kas_pkg::BOARD_WIDTH_DEF,
  parameter int STEP_COUNT_BITS = kas_pkg::STEP_COUNT_BITS_DEF,
  parameter int NW              = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kas_pkg::cfg_t       cfg,
  input  kas_pkg::in_item_t   item,
  input  logic                commit,
  output kas_pkg::cmd_pair_t  cmds,
  output logic [NW-1:0]       count
);

  localparam int CW = STEP_COUNT_BITS;
  localparam int EW = (CW > kas_pkg::CFG_W) ? CW : kas_pkg::CFG_W;
  localparam logic [CW-1:0] CNT_MAX = '1;

  kas_pkg::dir_e act_r, act_nxt;
  logic [CW-1:0] chg_r, chg_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  logic          rep_r, rep_nxt;
  logic          pp_r, pp_nxt;
  logic          pd_r, pd_nxt;

  logic [EW-1:0] delay_ext, repeat_ext, switch_ext;
  logic [CW-1:0] das, arr, dcd;

  // Delay and repeat clamp to the counter maximum, switch to the delay.
  assign delay_ext  = EW'(cfg.delay_steps);
  assign repeat_ext = EW'(cfg.repeat_steps);
  assign switch_ext = EW'(cfg.switch_delay_steps);
  assign das = (delay_ext > EW'(CNT_MAX)) ? CNT_MAX : delay_ext[CW-1:0];
  assign arr = (repeat_ext > EW'(CNT_MAX)) ? CNT_MAX : repeat_ext[CW-1:0];
  assign dcd = (switch_ext > EW'(das)) ? das : switch_ext[CW-1:0];

  always_comb begin
    kas_pkg::dir_e pdir;
    kas_pkg::dir_e fdir;
    logic          started;
    logic          sw;
    logic          other_held;
    logic [CW-1:0] chg_inc;
    logic [CW-1:0] rc_inc;

    act_nxt = act_r;
    chg_nxt = chg_r;
    rc_nxt  = rc_r;
    rep_nxt = rep_r;
    pp_nxt  = pp_r;
    pd_nxt  = pd_r;
    cmds.cmd_a = kas_pkg::CMD_ROTCW;
    cmds.cmd_b = kas_pkg::CMD_ROTCW;
    count   = '0;
    started = 1'b0;
    pdir    = pd_r ? kas_pkg::DIR_RIGHT : kas_pkg::DIR_LEFT;
    fdir    = kas_pkg::DIR_NONE;
    sw      = 1'b0;
    other_held = 1'b0;
    chg_inc = (chg_r != CNT_MAX) ? chg_r + CW'(1) : chg_r;
    rc_inc  = (rc_r != CNT_MAX) ? rc_r + CW'(1) : rc_r;

    if (item.mode == kas_pkg::MODE_EDGE) begin
      case (item.edge_code)
        kas_pkg::EDGE_ROTCW, kas_pkg::EDGE_ROTCCW, kas_pkg::EDGE_HARDDROP,
        kas_pkg::EDGE_HOLD, kas_pkg::EDGE_SOFTON, kas_pkg::EDGE_SOFTOFF: begin
          cmds.cmd_a = kas_pkg::cmd_e'(item.edge_code[2:0]);
          cmds.cmd_b = cmds.cmd_a;
          count      = NW'(1);
        end
        kas_pkg::EDGE_LPRESS: begin
          pp_nxt = 1'b1;
          pd_nxt = 1'b0;
        end
        kas_pkg::EDGE_RPRESS: begin
          pp_nxt = 1'b1;
          pd_nxt = 1'b1;
        end
        default: ;
      endcase
    end else begin
      if (pp_r) begin
        sw = (act_r != kas_pkg::DIR_NONE) && (act_r != pdir);
        cmds.cmd_a = kas_pkg::move_cmd(pdir);
        cmds.cmd_b = cmds.cmd_a;
        count   = NW'(1);
        act_nxt = pdir;
        rc_nxt  = '0;
        rep_nxt = 1'b0;
        chg_nxt = sw ? das - dcd : '0;
        pp_nxt  = 1'b0;
        started = 1'b1;
      end
      // The active key was let go: fall back to the other key or stop.
      if ((act_nxt == kas_pkg::DIR_LEFT && !item.left_held) ||
          (act_nxt == kas_pkg::DIR_RIGHT && !item.right_held)) begin
        other_held = (act_nxt == kas_pkg::DIR_LEFT) ? item.right_held : item.left_held;
        fdir = (act_nxt == kas_pkg::DIR_LEFT) ? kas_pkg::DIR_RIGHT : kas_pkg::DIR_LEFT;
        if (other_held) begin
          cmds.cmd_b = kas_pkg::move_cmd(fdir);
          if (!started) begin
            cmds.cmd_a = cmds.cmd_b;
          end
          count   = count + NW'(1);
          act_nxt = fdir;
          started = 1'b1;
        end else begin
          act_nxt = kas_pkg::DIR_NONE;
        end
        rc_nxt  = '0;
        rep_nxt = 1'b0;
        chg_nxt = '0;
      end
      if (act_nxt != kas_pkg::DIR_NONE && !started) begin
        cmds.cmd_a = kas_pkg::move_cmd(act_nxt);
        cmds.cmd_b = cmds.cmd_a;
        if (!rep_r) begin
          chg_nxt = chg_inc;
          if (chg_inc >= das) begin
            rep_nxt = 1'b1;
            rc_nxt  = '0;
            count   = (arr == '0) ? NW'(BOARD_WIDTH) : NW'(1);
          end
        end else if (arr == '0) begin
          count = NW'(BOARD_WIDTH);
        end else if (rc_inc >= arr) begin
          count  = NW'(1);
          rc_nxt = '0;
        end else begin
          rc_nxt = rc_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= kas_pkg::DIR_NONE;
      chg_r <= '0;
      rc_r  <= '0;
      rep_r <= 1'b0;
      pp_r  <= 1'b0;
      pd_r  <= 1'b0;
    end else if (commit) begin
      act_r <= act_nxt;
      chg_r <= chg_nxt;
      rc_r  <= rc_nxt;
      rep_r <= rep_nxt;
      pp_r  <= pp_nxt;
      pd_r  <= pd_nxt;
    end
  end

`ifndef SYNTHESIS
  a_repeat_needs_dir: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r |-> act_r != kas_pkg::DIR_NONE)
    else $error("repeating with no active direction");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count <= NW'(BOARD_WIDTH) || count <= NW'(2))
    else $error("item causes more results than allowed");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    act_r == kas_pkg::DIR_NONE |-> chg_r == '0 && rc_r == '0)
    else $error("counters not cleared while stopped");
`endif

endmodule

// ----- rtl/kas_emit.sv -----
module kas_emit #(
  parameter int MAX_RES = kas_pkg::BOARD_WIDTH_DEF,
  parameter int NW      = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  kas_pkg::cmd_pair_t  cmds,
  input  logic [NW-1:0]       count,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output kas_pkg::out_item_t  out_data
);

  logic               v_r;
  logic               first_r;
  logic [NW-1:0]      rem_r;
  kas_pkg::cmd_pair_t cmds_r;
  logic               fire;

  assign fire = v_r && out_ready;
  assign free = !v_r || (out_ready && rem_r == NW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      first_r <= 1'b0;
    end else if (load) begin
      v_r     <= 1'b1;
      first_r <= 1'b1;
    end else if (fire) begin
      v_r     <= (rem_r != NW'(1));
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmds_r <= cmds;
      rem_r  <= count;
    end else if (fire) begin
      rem_r  <= rem_r - NW'(1);
    end
  end

  assign out_valid        = v_r;
  assign out_data.command = first_r ? cmds_r.cmd_a : cmds_r.cmd_b;
  assign out_data.last    = (rem_r == NW'(1));

`ifndef SYNTHESIS
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> rem_r != '0)
    else $error("result pending with nothing left to send");

  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> rem_r <= NW'(MAX_RES))
    else $error("more results pending than one item can cause");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && rem_r != NW'(1)) |=> v_r && !first_r)
    else $error("burst of results cut short");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("new results loaded over pending ones");
`endif

endmodule

// ----- rtl/key_autorepeat_shifter_top.sv -----
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    kas_pkg::in_item_t  (mode, edge_code, held levels)
// out_     output     out_valid / out_ready  kas_pkg::out_item_t (command, last)
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// An item is held in the input register and moves its results to the output register, from
// which its first result is offered. Items with no result flow one per cycle, and items with
// one result do so too while the receiver keeps out_ready high. An item with n results keeps
// the output register until all n are sent (n is at most BOARD_WIDTH, or two for key starts);
// the next item that causes results waits in the input register until the last is sent.
// Reset is synchronous and active low; it restores the register defaults and clears all
// key state at once, with no clearing pass.
module key_autorepeat_shifter_top #(
  parameter int BOARD_WIDTH     = kas_pkg::BOARD_WIDTH_DEF,
  parameter int STEP_COUNT_BITS = kas_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kas_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kas_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kas_pkg::CFG_W-1:0]      cfg_data
);

  localparam int MAX_RES = (BOARD_WIDTH > 2) ? BOARD_WIDTH : 2;
  localparam int NW      = $clog2(MAX_RES + 1);

  logic               in_v_r;
  kas_pkg::in_item_t  in_item_r;
  kas_pkg::cfg_t      cfg;
  kas_pkg::cmd_pair_t cmds;
  logic [NW-1:0]      count;
  logic               emit_free;
  logic               adv;

  assign cfg_ready = 1'b1;

  kas_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // An item with no results never waits on the output side.
  assign adv      = in_v_r && (count == '0 || emit_free);
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  kas_core #(
    .BOARD_WIDTH     (BOARD_WIDTH),
    .STEP_COUNT_BITS (STEP_COUNT_BITS),
    .NW              (NW)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (in_item_r),
    .commit (adv),
    .cmds   (cmds),
    .count  (count)
  );

  kas_emit #(
    .MAX_RES (MAX_RES),
    .NW      (NW)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && count != '0),
    .cmds      (cmds),
    .count     (count),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- test/key_autorepeat_shifter_top_tb.sv -----
`timescale 1ns / 1ps

module key_autorepeat_shifter_top_tb;

  localparam int CW = kas_pkg::CFG_W;
  localparam int BOARD_W = kas_pkg::BOARD_WIDTH_DEF;
  localparam logic [CW-1:0] CNT_MAX = CW'((1 << kas_pkg::STEP_COUNT_BITS_DEF) - 1);
  localparam logic [3:0] EDGE_CODE_MAX = 4'hF;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTLE_CYCLES = 2 * BOARD_W + 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS = 16;

  typedef struct packed {
    logic          mode;
    logic [3:0]    code;
    logic          lh;
    logic          rh;
    logic          typed;
    logic          has_cmd;
    kas_pkg::cmd_e cmd;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  kas_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kas_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kas_pkg::CFG_IDX_W-1:0] cfg_index = kas_pkg::CFG_DELAY;
  logic [CW-1:0] cfg_data = '0;

  key_autorepeat_shifter_top #(
    .BOARD_WIDTH(kas_pkg::BOARD_WIDTH_DEF),
    .STEP_COUNT_BITS(kas_pkg::STEP_COUNT_BITS_DEF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the shifter's registers and key state.
  logic [CW-1:0] das_reg = kas_pkg::DELAY_RESET;
  logic [CW-1:0] arr_reg = kas_pkg::REPEAT_RESET;
  logic [CW-1:0] dcd_reg = kas_pkg::SWITCH_RESET;
  kas_pkg::dir_e held_dir = kas_pkg::DIR_NONE;
  logic [CW-1:0] das_charge = '0;
  logic [CW-1:0] arr_count = '0;
  logic auto_repeat = 1'b0;
  logic press_waiting = 1'b0;
  logic press_right = 1'b0;

  kas_pkg::out_item_t step_cmds[$];
  kas_pkg::out_item_t expected_cmds[$];
  int errors = 0;

  // Key levels that the random sequences keep consistent with their presses.
  logic key_l = 1'b0;
  logic key_r = 1'b0;

  logic no_idle = 1'b0;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic void emit_cmd(input kas_pkg::cmd_e c);
    step_cmds.push_back(kas_pkg::out_item_t'{command: c, last: 1'b0});
  endfunction

  function automatic void emit_repeat(input kas_pkg::cmd_e c);
    if (arr_reg == 0) begin
      repeat (BOARD_W) emit_cmd(c);
    end else begin
      emit_cmd(c);
    end
  endfunction

  function automatic void start_move(input kas_pkg::dir_e d, input logic by_press);
    logic [CW-1:0] dcd;
    logic switching;
    switching = (held_dir != kas_pkg::DIR_NONE) && (held_dir != d);
    dcd = (dcd_reg > das_reg) ? das_reg : dcd_reg;
    emit_cmd((d == kas_pkg::DIR_LEFT) ? kas_pkg::CMD_LEFT : kas_pkg::CMD_RIGHT);
    held_dir = d;
    arr_count = '0;
    auto_repeat = 1'b0;
    das_charge = (by_press && switching) ? das_reg - dcd : '0;
  endfunction

  function automatic void advance_move();
    kas_pkg::cmd_e c;
    c = (held_dir == kas_pkg::DIR_LEFT) ? kas_pkg::CMD_LEFT : kas_pkg::CMD_RIGHT;
    if (!auto_repeat) begin
      if (das_charge != CNT_MAX) das_charge = das_charge + 1'b1;
      if (das_charge >= das_reg) begin
        auto_repeat = 1'b1;
        arr_count = '0;
        emit_repeat(c);
      end
    end else if (arr_reg == 0) begin
      emit_repeat(c);
    end else begin
      if (arr_count != CNT_MAX) arr_count = arr_count + 1'b1;
      if (arr_count >= arr_reg) begin
        emit_cmd(c);
        arr_count = '0;
      end
    end
  endfunction

  // Fills step_cmds with the commands one item causes and updates the key state.
  function automatic void predict_commands(input kas_pkg::in_item_t it);
    logic started;
    started = 1'b0;
    step_cmds.delete();
    if (it.mode == kas_pkg::MODE_EDGE) begin
      if (it.edge_code <= kas_pkg::EDGE_SOFTOFF) begin
        emit_cmd(kas_pkg::cmd_e'(it.edge_code[2:0]));
      end else if (it.edge_code == kas_pkg::EDGE_LPRESS ||
                   it.edge_code == kas_pkg::EDGE_RPRESS) begin
        press_waiting = 1'b1;
        press_right = (it.edge_code == kas_pkg::EDGE_RPRESS);
      end
    end else begin
      if (press_waiting) begin
        start_move(press_right ? kas_pkg::DIR_RIGHT : kas_pkg::DIR_LEFT, 1'b1);
        press_waiting = 1'b0;
        started = 1'b1;
      end
      if ((held_dir == kas_pkg::DIR_LEFT && !it.left_held) ||
          (held_dir == kas_pkg::DIR_RIGHT && !it.right_held)) begin
        if (held_dir == kas_pkg::DIR_LEFT && it.right_held) begin
          start_move(kas_pkg::DIR_RIGHT, 1'b0);
          started = 1'b1;
        end else if (held_dir == kas_pkg::DIR_RIGHT && it.left_held) begin
          start_move(kas_pkg::DIR_LEFT, 1'b0);
          started = 1'b1;
        end else begin
          held_dir = kas_pkg::DIR_NONE;
          das_charge = '0;
          arr_count = '0;
          auto_repeat = 1'b0;
        end
      end
      if (held_dir != kas_pkg::DIR_NONE && !started) advance_move();
    end
    if (step_cmds.size() != 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_command(input kas_pkg::out_item_t got);
    kas_pkg::out_item_t want;
    if (expected_cmds.size() == 0) begin
      $display("%0t: expected no command, got command %0d last %0d",
               $time, got.command, got.last);
      errors++;
      return;
    end
    want = expected_cmds.pop_front();
    if (got.command !== want.command) begin
      $display("%0t: command expected %0d, got %0d", $time, want.command, got.command);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
      errors++;
    end
  endfunction

  function automatic kas_pkg::in_item_t next_key_item();
    kas_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.mode = kas_pkg::MODE_EDGE;
    it.edge_code = kas_pkg::EDGE_ROTCW;
    it.left_held = 1'($urandom_range(0, 1));
    it.right_held = 1'($urandom_range(0, 1));
    if (pick < 10) begin
      it.edge_code = 4'($urandom_range(kas_pkg::EDGE_ROTCW, kas_pkg::EDGE_SOFTOFF));
    end else if (pick < 22) begin
      if ($urandom_range(0, 1)) begin
        key_l = 1'b1;
        it.edge_code = kas_pkg::EDGE_LPRESS;
      end else begin
        key_r = 1'b1;
        it.edge_code = kas_pkg::EDGE_RPRESS;
      end
    end else if (pick < 28) begin
      if ($urandom_range(0, 1)) begin
        key_l = 1'b0;
        it.edge_code = kas_pkg::EDGE_LREL;
      end else begin
        key_r = 1'b0;
        it.edge_code = kas_pkg::EDGE_RREL;
      end
    end else if (pick < 31) begin
      it.edge_code = 4'($urandom_range(kas_pkg::EDGE_RREL + 1, EDGE_CODE_MAX));
    end else begin
      // Most steps carry the levels that match the presses; a few are noise.
      it.mode = kas_pkg::MODE_STEP;
      it.edge_code = 4'($urandom_range(0, EDGE_CODE_MAX));
      if (pick >= 35) begin
        it.left_held = key_l;
        it.right_held = key_r;
      end
    end
    return it;
  endfunction

  task automatic offer_item(input kas_pkg::in_item_t it, input logic typed,
                            input logic has_cmd, input kas_pkg::cmd_e cmd);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_commands(it);
    if (typed) begin
      if (has_cmd) begin
        expected_cmds.push_back(kas_pkg::out_item_t'{command: cmd, last: 1'b1});
      end
    end else begin
      foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    end
  endtask

  task automatic write_reg(input kas_pkg::cfg_idx_e idx, input logic [CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      kas_pkg::CFG_DELAY: das_reg = val;
      kas_pkg::CFG_REPEAT: arr_reg = val;
      default: dcd_reg = val;
    endcase
  endtask

  // The block is idle once every command has come and the settling wait has passed.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CW-1:0] das, input logic [CW-1:0] arr,
                           input logic [CW-1:0] dcd, input logic squeeze);
    settle();
    write_reg(kas_pkg::CFG_DELAY, das);
    write_reg(kas_pkg::CFG_REPEAT, arr);
    write_reg(kas_pkg::CFG_SWITCH, dcd);
    cfg_valid <= 1'b0;
    if (squeeze) hold_off_req = 1'b1;
    repeat (PHASE_ITEMS) offer_item(next_key_item(), 1'b0, 1'b0, kas_pkg::CMD_ROTCW);
  endtask

  // Directed rows run with the reset register values.
  row_t directed_rows [24] = '{
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_ROTCW,    1'b1, 1'b0, 1'b1, 1'b1, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_ROTCCW,   1'b0, 1'b1, 1'b1, 1'b1, kas_pkg::CMD_ROTCCW},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_HARDDROP, 1'b1, 1'b1, 1'b1, 1'b1,
      kas_pkg::CMD_HARDDROP},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_HOLD,     1'b0, 1'b0, 1'b1, 1'b1, kas_pkg::CMD_HOLD},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_SOFTON,   1'b0, 1'b0, 1'b1, 1'b1, kas_pkg::CMD_SOFTON},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_SOFTOFF,  1'b0, 1'b0, 1'b1, 1'b1,
      kas_pkg::CMD_SOFTOFF},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_LREL,     1'b0, 1'b0, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_RREL,     1'b0, 1'b0, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_EDGE, EDGE_CODE_MAX,          1'b1, 1'b1, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b1, 1'b1, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_LPRESS,   1'b0, 1'b0, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_RPRESS,   1'b0, 1'b0, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b0, 1'b1, 1'b1, 1'b1, kas_pkg::CMD_RIGHT},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b0, 1'b1, 1'b0, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_LPRESS,   1'b0, 1'b0, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b1, 1'b1, 1'b1, 1'b1, kas_pkg::CMD_LEFT},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b1, 1'b1, 1'b0, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b0, 1'b1, 1'b0, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_RPRESS,   1'b0, 1'b0, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b0, 1'b1, 1'b0, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b0, 1'b0, 1'b0, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_EDGE, kas_pkg::EDGE_LPRESS,   1'b0, 1'b0, 1'b1, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_STEP, EDGE_CODE_MAX,          1'b0, 1'b1, 1'b0, 1'b0, kas_pkg::CMD_ROTCW},
    '{kas_pkg::MODE_STEP, kas_pkg::EDGE_ROTCW,    1'b0, 1'b0, 1'b0, 1'b0, kas_pkg::CMD_ROTCW}
  };

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_command(out_data);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        stall_left <= HOLD_OFF_CYCLES - 1;
        hold_off_done <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    kas_pkg::in_item_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      it.mode = directed_rows[i].mode;
      it.edge_code = directed_rows[i].code;
      it.left_held = directed_rows[i].lh;
      it.right_held = directed_rows[i].rh;
      offer_item(it, directed_rows[i].typed, directed_rows[i].has_cmd, directed_rows[i].cmd);
    end

    // Steps after a key start jump to the wall; the receiver holds off a while.
    run_phase(12'd0, 12'd0, 12'd0, 1'b1);
    run_phase(CNT_MAX, CNT_MAX, CNT_MAX, 1'b0);
    run_phase(12'd3, 12'd1, 12'd2, 1'b0);
    // A switch delay above the delay is clamped to it.
    run_phase(12'd2, 12'd0, CNT_MAX, 1'b0);
    run_phase(CW'($urandom_range(0, 6)), CW'($urandom_range(0, 6)),
              CW'($urandom_range(0, 6)), 1'b0);
    no_idle = 1'b1;
    run_phase(12'd5, 12'd3, 12'd1, 1'b0);

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
